[design/gamepad_debounce_report_defines.svh]
// Assertion macros for the gamepad debounce and report block.
// Taken in by the top level; no other dependencies.
`ifndef GAMEPAD_DEBOUNCE_REPORT_DEFINES_SVH
`define GAMEPAD_DEBOUNCE_REPORT_DEFINES_SVH
`ifndef SYNTH
`define GDR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define GDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define GDR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GDR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/gdr_pkg.sv]
// Shared types and constants for the gamepad debounce and report block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package gdr_pkg;

	localparam int NUM_BUTTONS   = 12;
	localparam int NUM_BITS      = 8;
	localparam int FIRST_BIT     = 4;
	localparam int LEVEL_W       = 12;
	localparam int CFG_TICK_W    = 8;
	localparam int CFG_HOLD_W    = 16;
	localparam int CFG_DATA_W    = 16;
	localparam int CFG_INDEX_W   = 2;
	localparam int DEF_RUN_BITS  = 8;
	localparam int DEF_LED_BITS  = 16;

	localparam int BTN_UP    = 0;
	localparam int BTN_DOWN  = 1;
	localparam int BTN_LEFT  = 2;
	localparam int BTN_RIGHT = 3;

	localparam logic [1:0] AXIS_NEG    = 2'd0;
	localparam logic [1:0] AXIS_CENTRE = 2'd1;
	localparam logic [1:0] AXIS_POS    = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_PRESS_TICKS   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_TICKS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LED_HOLD      = 2'd2;

	localparam logic [CFG_TICK_W-1:0] RST_PRESS_TICKS   = 8'd10;
	localparam logic [CFG_TICK_W-1:0] RST_RELEASE_TICKS = 8'd10;
	localparam logic [CFG_HOLD_W-1:0] RST_LED_HOLD      = 16'd500;

	typedef struct packed {
		logic fire;
		logic press;
	} gdr_event_t;

	typedef struct packed {
		logic [1:0]          x_axis_code;
		logic [1:0]          y_axis_code;
		logic [NUM_BITS-1:0] button_bits;
		logic                report_strobe;
		logic                led_on;
		logic                any_press;
	} gdr_report_t;

endpackage

[design/gamepad_debounce_report.sv]
// Top level of the gamepad debounce and report block: configuration registers,
// twelve debounce lanes, the merging stage and the output register.
// Depends on gdr_pkg, gdr_lane, gdr_merge and gamepad_debounce_report_defines.svh.
//
// Each transfer on the slave stream is one sampling tick carrying the raw levels
// of twelve buttons in s_tdata; a low level means pressed. Every tick yields
// exactly one report on the master stream: axis codes, button bits and the
// indicator flag in m_tdata, and in m_tuser a strobe that is high when any
// debounced press or release fired on that tick.
// All twelve lanes and the merging stage act in the cycle of the transfer, and
// the report lands in a single output register in the cycle after the transfer;
// a new tick is taken every cycle while the output is not stalled. The only
// thing that holds the input back is a report still waiting in the output
// register while m_tready is low; s_tready then drops until the report is taken.
// Reset releases all buttons, disarms every run counter, centres both axes,
// clears the button bits, turns the indicator off and loads the register
// defaults of 10, 10 and 500 ticks. The user writes registers through cfg_we,
// cfg_index and cfg_data only while the stream is idle; the block does not enforce it.
`timescale 1ns / 1ps
`include "gamepad_debounce_report_defines.svh"

module gamepad_debounce_report #(
	parameter int RUN_BITS = gdr_pkg::DEF_RUN_BITS,
	parameter int LED_BITS = gdr_pkg::DEF_LED_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [15:0]                        s_tdata,  // [11:0] button_levels
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [15:0]                        m_tdata,  // [1:0] x_axis_code, [3:2] y_axis_code,
	                                                     // [11:4] button_bits, [12] led_on
	output logic                               m_tuser,  // [0] report_strobe
	input  logic                               cfg_we,
	input  logic [gdr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [gdr_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import gdr_pkg::*;

	localparam int THR_W = RUN_BITS > CFG_TICK_W ? RUN_BITS : CFG_TICK_W;
	localparam logic [THR_W-1:0] RUN_MAX_EXT = THR_W'({RUN_BITS{1'b1}});

	logic [CFG_TICK_W-1:0] press_ticks_q;
	logic [CFG_TICK_W-1:0] release_ticks_q;
	logic [CFG_HOLD_W-1:0] led_hold_q;

	logic [THR_W-1:0]    press_ext;
	logic [THR_W-1:0]    release_ext;
	logic [RUN_BITS-1:0] press_thr;
	logic [RUN_BITS-1:0] release_thr;

	logic                advance;
	logic [LEVEL_W-1:0]  levels;
	gdr_event_t          evts [NUM_BUTTONS];
	gdr_report_t         rpt;

	logic                out_valid_q;
	logic [15:0]         out_data_q;
	logic                out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_ticks_q   <= RST_PRESS_TICKS;
			release_ticks_q <= RST_RELEASE_TICKS;
			led_hold_q      <= RST_LED_HOLD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PRESS_TICKS: begin
					press_ticks_q <= cfg_data[CFG_TICK_W-1:0];
				end
				REG_RELEASE_TICKS: begin
					release_ticks_q <= cfg_data[CFG_TICK_W-1:0];
				end
				REG_LED_HOLD: begin
					led_hold_q <= cfg_data[CFG_HOLD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		press_ext   = THR_W'(press_ticks_q);
		release_ext = THR_W'(release_ticks_q);
		press_thr   = RUN_BITS'(press_ext > RUN_MAX_EXT ? RUN_MAX_EXT : press_ext);
		release_thr = RUN_BITS'(release_ext > RUN_MAX_EXT ? RUN_MAX_EXT : release_ext);
	end

	assign s_tready = ~out_valid_q | m_tready;
	assign advance  = s_tvalid & s_tready;
	assign levels   = s_tdata[LEVEL_W-1:0];

	for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
		gdr_lane #(
			.RUN_BITS(RUN_BITS)
		) u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.advance     (advance),
			.level       (levels[g]),
			.press_thr   (press_thr),
			.release_thr (release_thr),
			.evt         (evts[g])
		);
	end

	gdr_merge #(
		.LED_BITS(LED_BITS)
	) u_merge (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.evts           (evts),
		.led_hold_ticks (led_hold_q),
		.rpt            (rpt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {3'b000, rpt.led_on, rpt.button_bits,
				rpt.y_axis_code, rpt.x_axis_code};
			out_user_q <= rpt.report_strobe;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	`GDR_ASSERT_IMP(a_stall_blocks_input, clk, arst_n, m_tvalid && !m_tready, !s_tready)
	`GDR_ASSERT_NEXT(a_axis_codes_valid, clk, arst_n, advance,
		m_tdata[1:0] != AXIS_NEG - 2'd1 && m_tdata[3:2] != AXIS_NEG - 2'd1)
	`GDR_ASSERT_NEXT(a_press_lights_led, clk, arst_n,
		advance && rpt.any_press && led_hold_q != '0, m_tdata[12] && m_tuser)

endmodule

[design/gdr_lane.sv]
// One debounce lane: run counter, arm flag and last level for a single button.
// Depends on gdr_pkg.
`timescale 1ns / 1ps

module gdr_lane #(
	parameter int RUN_BITS = gdr_pkg::DEF_RUN_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic                level,
	input  logic [RUN_BITS-1:0] press_thr,
	input  logic [RUN_BITS-1:0] release_thr,
	output gdr_pkg::gdr_event_t evt
);
	import gdr_pkg::*;

	logic                last_q;
	logic                armed_q;
	logic [RUN_BITS-1:0] count_q;

	logic                changed;
	logic                armed_now;
	logic [RUN_BITS-1:0] cnt_now;
	logic [RUN_BITS-1:0] thr;
	logic                below;
	logic                armed_d;
	logic [RUN_BITS-1:0] count_d;

	always_comb begin
		changed   = level != last_q;
		armed_now = armed_q | changed;
		cnt_now   = changed ? '0 : count_q;
		thr       = level ? release_thr : press_thr;
		below     = cnt_now < thr;
		armed_d   = armed_now & below;
		count_d   = armed_d ? cnt_now + RUN_BITS'(1) : '0;
		evt.fire  = armed_now & ~below;
		evt.press = ~level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= 1'b1;
			armed_q <= 1'b0;
			count_q <= '0;
		end else if (advance) begin
			last_q  <= level;
			armed_q <= armed_d;
			count_q <= count_d;
		end
	end

endmodule

[design/gdr_merge.sv]
// Merging stage: folds the lane events into the axis codes, button bits and
// indicator hold counter. Depends on gdr_pkg.
`timescale 1ns / 1ps

module gdr_merge #(
	parameter int LED_BITS = gdr_pkg::DEF_LED_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                advance,
	input  gdr_pkg::gdr_event_t                 evts [gdr_pkg::NUM_BUTTONS],
	input  logic [gdr_pkg::CFG_HOLD_W-1:0]      led_hold_ticks,
	output gdr_pkg::gdr_report_t                rpt
);
	import gdr_pkg::*;

	localparam int HOLD_W = LED_BITS > CFG_HOLD_W ? LED_BITS : CFG_HOLD_W;
	localparam logic [HOLD_W-1:0] LED_MAX_EXT = HOLD_W'({LED_BITS{1'b1}});

	logic [1:0]          axis_x_q;
	logic [1:0]          axis_y_q;
	logic [NUM_BITS-1:0] pressed_q;
	logic [LED_BITS-1:0] led_count_q;

	logic [1:0]          axis_x_d;
	logic [1:0]          axis_y_d;
	logic [NUM_BITS-1:0] pressed_d;
	logic [LED_BITS-1:0] led_count_d;
	logic [HOLD_W-1:0]   hold_ext;
	logic [LED_BITS-1:0] hold_sat;
	logic                any_event;
	logic                any_press;

	always_comb begin
		any_event = 1'b0;
		any_press = 1'b0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			any_event = any_event | evts[i].fire;
			any_press = any_press | (evts[i].fire & evts[i].press);
		end

		// A later button in the order overrides an earlier one on the same axis.
		axis_y_d = axis_y_q;
		if (evts[BTN_UP].fire) begin
			axis_y_d = evts[BTN_UP].press ? AXIS_NEG : AXIS_CENTRE;
		end
		if (evts[BTN_DOWN].fire) begin
			axis_y_d = evts[BTN_DOWN].press ? AXIS_POS : AXIS_CENTRE;
		end
		axis_x_d = axis_x_q;
		if (evts[BTN_LEFT].fire) begin
			axis_x_d = evts[BTN_LEFT].press ? AXIS_NEG : AXIS_CENTRE;
		end
		if (evts[BTN_RIGHT].fire) begin
			axis_x_d = evts[BTN_RIGHT].press ? AXIS_POS : AXIS_CENTRE;
		end

		pressed_d = pressed_q;
		for (int k = 0; k < NUM_BITS; k++) begin
			if (evts[k + FIRST_BIT].fire) begin
				pressed_d[k] = evts[k + FIRST_BIT].press;
			end
		end

		hold_ext = HOLD_W'(led_hold_ticks);
		hold_sat = LED_BITS'(hold_ext > LED_MAX_EXT ? LED_MAX_EXT : hold_ext);
		if (any_press) begin
			led_count_d = hold_sat;
		end else if (led_count_q != '0) begin
			led_count_d = led_count_q - LED_BITS'(1);
		end else begin
			led_count_d = led_count_q;
		end

		rpt.x_axis_code   = axis_x_d;
		rpt.y_axis_code   = axis_y_d;
		rpt.button_bits   = pressed_d;
		rpt.report_strobe = any_event;
		rpt.led_on        = led_count_d != '0;
		rpt.any_press     = any_press;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_x_q    <= AXIS_CENTRE;
			axis_y_q    <= AXIS_CENTRE;
			pressed_q   <= '0;
			led_count_q <= '0;
		end else if (advance) begin
			axis_x_q    <= axis_x_d;
			axis_y_q    <= axis_y_d;
			pressed_q   <= pressed_d;
			led_count_q <= led_count_d;
		end
	end

endmodule
